// File: hw/rtl/mwtc_pkg.sv
// Shared constants and types for the minimum window token cover block.
package mwtc_pkg;

    // Token alphabet and window ring size (both powers of two)
    localparam int TOKEN_COUNT  = 256;
    localparam int WINDOW_DEPTH = 256;

    localparam int TOK_W  = $clog2(TOKEN_COUNT);
    localparam int RING_W = $clog2(WINDOW_DEPTH);
    localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);

    // Fixed widths of the item fields
    localparam int KIND_W      = 1;
    localparam int TOKEN_IN_W  = 8;
    localparam int POS_W       = 32;
    localparam int BEST_LEN_W  = 9;

    // Per-token deficit, two's complement, saturating on load. Loads that
    // only cancel surplus copies in the window can lift a required count up
    // to 511 plus the window depth, so the deficit and the missing total
    // grow past the load caps once those copies leave the window.
    localparam int DEF_W  = 11;
    localparam int MISS_W = 18;
    localparam logic [DEF_W-1:0]  DEF_MAX  = DEF_W'(511);
    localparam logic [MISS_W-1:0] MISS_MAX = MISS_W'(511);

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_PARA = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [TOK_W-1:0] token;
    } t_cmd;

    typedef struct packed {
        logic             tgt;
        logic [DEF_W-1:0] def;
    } t_tok_ent;

    localparam int TOK_ENT_W = DEF_W + 1;

endpackage

// File: hw/rtl/mwtc_if.sv
// Valid/ready channel interfaces for input words and result words.
interface mwtc_in_if;
    import mwtc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [TOKEN_IN_W-1:0] token;

    modport source (output valid, output kind, output token, input ready);
    modport sink   (input valid, input kind, input token, output ready);
endinterface

interface mwtc_out_if;
    import mwtc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [POS_W-1:0]      best_start;
    logic [BEST_LEN_W-1:0] best_length;
    logic                  found;
    logic                  overflow;

    modport source (output valid, output best_start, output best_length,
                    output found, output overflow, input ready);
    modport sink   (input valid, input best_start, input best_length,
                    input found, input overflow, output ready);
endinterface

// File: hw/rtl/mwtc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mwtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/mwtc_front.sv
// Front end: accepts input words, reduces the token and classifies the operation.
module mwtc_front import mwtc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mwtc_in_if.sink    i_item,
    output t_cmd       o_cmd,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready
);

    logic r_vld;
    t_cmd r_cmd;
    logic take;

    assign i_item.ready = !r_vld || i_cmd_ready;
    assign take         = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_cmd_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd.op    <= (i_item.kind[0]) ? OP_PARA : OP_LOAD;
            // token modulo the alphabet size
            r_cmd.token <= i_item.token[TOK_W-1:0];
        end
    end

    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_vld;

endmodule

// File: hw/rtl/mwtc_queue.sv
// Short command queue between the front end and the window engine.
module mwtc_queue import mwtc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_valid,
    output logic o_cmd_ready,
    output t_cmd o_cmd,
    output logic o_cmd_valid,
    input  logic i_cmd_ready
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0]   r_wptr;
    logic [QP_W-1:0]   r_rptr;
    logic [QC_W-1:0]   r_cnt;
    logic              push;
    logic              pop;

    assign o_cmd_ready = (r_cnt != QC_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rptr];
    assign push        = i_cmd_valid && o_cmd_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + QP_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + QP_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QC_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// File: hw/rtl/mwtc_back.sv
// Window engine: token table, window ring, shrink loop and result register.
module mwtc_back import mwtc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    mwtc_out_if.source  o_result
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE     = 4'd0;
    localparam logic [ST_W-1:0] S_RD       = 4'd1;
    localparam logic [ST_W-1:0] S_OVF_RING = 4'd2;
    localparam logic [ST_W-1:0] S_OVF_TOK  = 4'd3;
    localparam logic [ST_W-1:0] S_OVF_POP  = 4'd4;
    localparam logic [ST_W-1:0] S_PUSH_RD  = 4'd5;
    localparam logic [ST_W-1:0] S_PUSH     = 4'd6;
    localparam logic [ST_W-1:0] S_SH_RING  = 4'd7;
    localparam logic [ST_W-1:0] S_SH_TOK   = 4'd8;
    localparam logic [ST_W-1:0] S_SH_POP   = 4'd9;
    localparam logic [ST_W-1:0] S_DONE     = 4'd10;

    logic [ST_W-1:0]   r_state, n_state;
    t_op               r_op, n_op;
    logic [TOK_W-1:0]  r_tok, n_tok;
    logic [TOK_W-1:0]  r_front, n_front;
    logic [RING_W-1:0] r_head, n_head;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [POS_W-1:0]  r_start, n_start;
    logic [MISS_W-1:0] r_missing, n_missing;
    logic [POS_W-1:0]  r_best_pos, n_best_pos;
    logic [LEN_W-1:0]  r_best_len, n_best_len;
    logic              r_found, n_found;
    logic              r_ovf, n_ovf;
    logic              r_tok_vld [TOKEN_COUNT];
    logic              r_q_vld;

    logic                  r_out_vld;
    logic [POS_W-1:0]      r_out_start;
    logic [BEST_LEN_W-1:0] r_out_len;
    logic                  r_out_found;
    logic                  r_out_ovf;

    // token table port
    logic              tok_we, tok_re;
    logic [TOK_W-1:0]  tok_waddr, tok_raddr;
    t_tok_ent          tok_wdata, tok_q, ent;
    logic [TOK_ENT_W-1:0] tok_q_raw;
    // window ring port
    logic              ring_we, ring_re;
    logic [RING_W-1:0] ring_waddr, ring_raddr;
    logic [TOK_W-1:0]  ring_wdata, ring_q;

    logic [DEF_W-1:0]  d_inc, d_dec;
    logic [MISS_W-1:0] push_miss, pop_miss;
    logic [LEN_W-1:0]  pop_len;
    logic              load_adds;
    logic              do_push, do_pop, emit, out_free;

    mwtc_ram #(.WIDTH(TOK_ENT_W), .DEPTH(TOKEN_COUNT)) u_tok_ram (
        .i_clk   (i_clk),
        .i_we    (tok_we),
        .i_waddr (tok_waddr),
        .i_wdata (tok_wdata),
        .i_re    (tok_re),
        .i_raddr (tok_raddr),
        .o_rdata (tok_q_raw)
    );

    mwtc_ram #(.WIDTH(TOK_W), .DEPTH(WINDOW_DEPTH)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_q)
    );

    assign tok_q = t_tok_ent'(tok_q_raw);
    // an entry never written reads as cleared
    assign ent   = r_q_vld ? tok_q : '0;
    assign d_inc = ent.def + DEF_W'(1);
    assign d_dec = ent.def - DEF_W'(1);

    assign push_miss = (!d_dec[DEF_W-1] && r_missing != '0) ?
                       r_missing - MISS_W'(1) : r_missing;
    assign pop_miss  = (!d_inc[DEF_W-1] && d_inc != '0) ?
                       r_missing + MISS_W'(1) : r_missing;
    assign pop_len   = r_len - LEN_W'(1);
    assign load_adds = !ent.def[DEF_W-1];

    assign out_free    = !r_out_vld || o_result.ready;
    assign o_cmd_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_tok      = r_tok;
        n_front    = r_front;
        n_head     = r_head;
        n_len      = r_len;
        n_start    = r_start;
        n_missing  = r_missing;
        n_best_pos = r_best_pos;
        n_best_len = r_best_len;
        n_found    = r_found;
        n_ovf      = r_ovf;
        tok_we     = 1'b0;
        tok_waddr  = r_tok;
        tok_wdata  = ent;
        tok_re     = 1'b0;
        tok_raddr  = r_tok;
        ring_we    = 1'b0;
        ring_waddr = r_head + r_len[RING_W-1:0];
        ring_wdata = r_tok;
        ring_re    = 1'b0;
        ring_raddr = r_head;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        emit       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_op      = i_cmd.op;
                    n_tok     = i_cmd.token;
                    tok_re    = 1'b1;
                    tok_raddr = i_cmd.token;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                if (r_op == OP_LOAD) begin
                    tok_we        = 1'b1;
                    tok_wdata.tgt = 1'b1;
                    // saturate: drop the count but keep the target mark
                    if ($signed(ent.def) < $signed(DEF_MAX) &&
                        (!load_adds || r_missing < MISS_MAX)) begin
                        tok_wdata.def = d_inc;
                        if (load_adds) begin
                            n_missing = r_missing + MISS_W'(1);
                        end
                    end
                    n_state = S_DONE;
                end else if (r_len == '0 && !ent.tgt) begin
                    n_start = r_start + POS_W'(1);
                    n_state = S_DONE;
                end else if (r_len == LEN_W'(WINDOW_DEPTH)) begin
                    n_ovf   = 1'b1;
                    n_state = S_OVF_RING;
                end else begin
                    do_push = 1'b1;
                    n_state = (push_miss == '0) ? S_SH_RING : S_DONE;
                end
            end
            S_OVF_RING: begin
                ring_re = 1'b1;
                n_state = S_OVF_TOK;
            end
            S_OVF_TOK: begin
                n_front   = ring_q;
                tok_re    = 1'b1;
                tok_raddr = ring_q;
                n_state   = S_OVF_POP;
            end
            S_OVF_POP: begin
                do_pop  = 1'b1;
                n_state = S_PUSH_RD;
            end
            S_PUSH_RD: begin
                // reread: the dropped token may be the one being pushed
                tok_re  = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                do_push = 1'b1;
                n_state = (push_miss == '0) ? S_SH_RING : S_DONE;
            end
            S_SH_RING: begin
                ring_re = 1'b1;
                n_state = S_SH_TOK;
            end
            S_SH_TOK: begin
                n_front   = ring_q;
                tok_re    = 1'b1;
                tok_raddr = ring_q;
                n_state   = S_SH_POP;
            end
            S_SH_POP: begin
                // ties keep the earlier window
                if (!r_found || r_len < r_best_len) begin
                    n_best_pos = r_start;
                    n_best_len = r_len;
                    n_found    = 1'b1;
                end
                do_pop  = 1'b1;
                n_state = (pop_miss == '0 && pop_len != '0) ? S_SH_RING : S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_push) begin
            ring_we       = 1'b1;
            tok_we        = 1'b1;
            tok_waddr     = r_tok;
            tok_wdata.def = d_dec;
            n_len         = r_len + LEN_W'(1);
            n_missing     = push_miss;
        end
        if (do_pop) begin
            tok_we        = 1'b1;
            tok_waddr     = r_front;
            tok_wdata.def = d_inc;
            n_missing     = pop_miss;
            n_head        = r_head + RING_W'(1);
            n_len         = pop_len;
            n_start       = r_start + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_len      <= '0;
            r_start    <= '0;
            r_missing  <= '0;
            r_best_pos <= '0;
            r_best_len <= '0;
            r_found    <= 1'b0;
            r_ovf      <= 1'b0;
            r_q_vld    <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int i = 0; i < TOKEN_COUNT; i++) begin
                r_tok_vld[i] <= 1'b0;
            end
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_len      <= n_len;
            r_start    <= n_start;
            r_missing  <= n_missing;
            r_best_pos <= n_best_pos;
            r_best_len <= n_best_len;
            r_found    <= n_found;
            r_ovf      <= n_ovf;
            if (tok_we) begin
                r_tok_vld[tok_waddr] <= 1'b1;
            end
            if (tok_re) begin
                r_q_vld <= r_tok_vld[tok_raddr];
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_tok   <= n_tok;
        r_front <= n_front;
        if (emit) begin
            r_out_start <= r_best_pos;
            r_out_len   <= BEST_LEN_W'(r_best_len);
            r_out_found <= r_found;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_result.valid       = r_out_vld;
    assign o_result.best_start  = r_out_start;
    assign o_result.best_length = r_out_len;
    assign o_result.found       = r_out_found;
    assign o_result.overflow    = r_out_ovf;

endmodule

// File: hw/rtl/min_window_token_cover_top.sv
// Top level of the minimum window token cover block.
// Takes a stream of words (load a required token, or append a paragraph
// token) and answers every word with the best covering window so far, a
// found flag and a sticky overflow flag. A front stage and a two-word queue
// take words while the window engine works; the engine handles one word at a
// time. A load, a skipped token, or a push that does not complete the cover
// passes through the read and done states; a push that completes the cover adds
// a ring read, a token read and a pop per token dropped from the front, and a
// push into a full ring first drops the oldest token and rereads the table.
// Each token is dropped at most once. The per-drop cost is set by the ring
// read followed by the token table read-modify-write, both RAMs with registered reads.
// No clearing pass follows reset: the token table is covered by
// per-entry valid bits.
module min_window_token_cover_top import mwtc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mwtc_in_if.sink    i_item,
    mwtc_out_if.source o_result
);

    t_cmd front_cmd;
    logic front_valid;
    logic front_ready;
    t_cmd queue_cmd;
    logic queue_valid;
    logic queue_ready;

    mwtc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready)
    );

    mwtc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (front_cmd),
        .i_cmd_valid (front_valid),
        .o_cmd_ready (front_ready),
        .o_cmd       (queue_cmd),
        .o_cmd_valid (queue_valid),
        .i_cmd_ready (queue_ready)
    );

    mwtc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .o_result    (o_result)
    );

endmodule

// File: verif/min_window_token_cover_checker.sv
// Best-window predictor and result comparison for the token cover block.
module min_window_token_cover_checker import mwtc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mwtc_in_if   i_item,
    mwtc_out_if  i_result,
    output int   o_pending,
    output int   o_checked,
    output int   o_fail_count
);

    typedef struct packed {
        logic [POS_W-1:0]      start;
        logic [BEST_LEN_W-1:0] length;
        logic                  found;
        logic                  overflow;
    } t_best_window;

    // Predicted cover state
    bit                    needed    [TOKEN_COUNT];
    int                    shortfall [TOKEN_COUNT];
    logic [TOK_W-1:0]      ring_tok  [WINDOW_DEPTH];
    logic [RING_W-1:0]     ring_head;
    logic [POS_W-1:0]      win_start;
    int                    win_len;
    int                    missing;
    logic [POS_W-1:0]      best_pos;
    logic [BEST_LEN_W-1:0] best_len;
    bit                    found_any;
    bit                    ring_full_seen;

    t_best_window best_due[$];
    int           checked_total;
    int           fail_total;

    function automatic void clear_cover();
        foreach (needed[k]) begin
            needed[k]    = 1'b0;
            shortfall[k] = 0;
        end
        ring_head      = '0;
        win_start      = '0;
        win_len        = 0;
        missing        = 0;
        best_pos       = '0;
        best_len       = '0;
        found_any      = 1'b0;
        ring_full_seen = 1'b0;
    endfunction

    function automatic void drop_front();
        logic [TOK_W-1:0] tok;
        tok = ring_tok[ring_head];
        shortfall[tok]++;
        if (shortfall[tok] > 0)
            missing++;
        ring_head++;
        win_len--;
        win_start++;
    endfunction

    function automatic t_best_window advance_cover(t_op op, logic [TOK_W-1:0] tok);
        t_best_window      res;
        logic [RING_W-1:0] slot;
        if (op == OP_LOAD) begin
            needed[tok] = 1'b1;
            // saturate: the load still marks the token as required
            if (shortfall[tok] < int'(DEF_MAX)) begin
                if (shortfall[tok] + 1 <= 0) begin
                    shortfall[tok]++;
                end else if (missing < int'(MISS_MAX)) begin
                    shortfall[tok]++;
                    missing++;
                end
            end
        end else if (win_len == 0 && !needed[tok]) begin
            win_start++;
        end else begin
            if (win_len >= WINDOW_DEPTH) begin
                ring_full_seen = 1'b1;
                drop_front();
            end
            slot           = ring_head + RING_W'(win_len);
            ring_tok[slot] = tok;
            win_len++;
            shortfall[tok]--;
            if (shortfall[tok] >= 0 && missing > 0)
                missing--;
            // shrink from the front while covered; ties keep the earlier window
            while (missing == 0 && win_len > 0) begin
                if (!found_any || win_len < best_len) begin
                    best_pos  = win_start;
                    best_len  = BEST_LEN_W'(win_len);
                    found_any = 1'b1;
                end
                drop_front();
            end
        end
        res.start    = best_pos;
        res.length   = best_len;
        res.found    = found_any;
        res.overflow = ring_full_seen;
        return res;
    endfunction

    function automatic void compare_field(string name, logic [POS_W-1:0] want,
                                          logic [POS_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_best_window want;
        t_best_window got;
        if (!i_rst_n) begin
            clear_cover();
            best_due.delete();
            checked_total = 0;
            fail_total    = 0;
        end else begin
            if (i_item.valid && i_item.ready)
                best_due.push_back(advance_cover(t_op'(i_item.kind), TOK_W'(i_item.token)));
            if (i_result.valid && i_result.ready) begin
                got.start    = i_result.best_start;
                got.length   = i_result.best_length;
                got.found    = i_result.found;
                got.overflow = i_result.overflow;
                if (best_due.size() == 0) begin
                    $display("%0t: result word with nothing expected: got start %0d len %0d",
                             $time, got.start, got.length);
                    fail_total++;
                end else begin
                    want = best_due.pop_front();
                    compare_field("best_start", want.start, got.start);
                    compare_field("best_length", POS_W'(want.length), POS_W'(got.length));
                    compare_field("found", POS_W'(want.found), POS_W'(got.found));
                    compare_field("overflow", POS_W'(want.overflow), POS_W'(got.overflow));
                    checked_total++;
                end
            end
        end
        o_pending    <= best_due.size();
        o_checked    <= checked_total;
        o_fail_count <= fail_total;
    end

endmodule

// File: verif/min_window_token_cover_top_tb.sv
// Stimulus and verdict for the minimum window token cover block.
module min_window_token_cover_top_tb;
    import mwtc_pkg::*;

    localparam int POOL_SIZE      = 8;
    localparam int MIXED_WORDS    = 300;
    localparam int FILL_WORDS     = 280;
    localparam int TAIL_CYCLES    = 64;
    localparam int RUN_LIMIT      = 6_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mwtc_in_if  item_ch ();
    mwtc_out_if result_ch ();

    int pending;
    int checked;
    int fail_count;
    int words_sent = 0;
    int loads_sent = 0;
    int burst_left = 0;
    int ready_pct  = 100;
    int ready_left = 0;

    logic [TOKEN_IN_W-1:0] pool [POOL_SIZE];
    logic [TOKEN_IN_W-1:0] gate_tok;

    min_window_token_cover_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    min_window_token_cover_checker cover_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_fail_count (fail_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: stretches of different ready density, fully ready included
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_left <= $urandom_range(40, 200);
            case ($urandom_range(0, 3))
                0: ready_pct <= 100;
                1: ready_pct <= 75;
                2: ready_pct <= 40;
                default: ready_pct <= 10;
            endcase
        end else begin
            ready_left <= ready_left - 1;
        end
        result_ch.ready <= ($urandom_range(0, 99) < ready_pct);
    end

    function automatic logic [TOKEN_IN_W-1:0] fresh_token(logic [TOKEN_IN_W-1:0] also_avoid);
        logic [TOKEN_IN_W-1:0] tok;
        bit                    clash;
        do begin
            tok   = TOKEN_IN_W'($urandom_range(1, 254));
            clash = (tok == also_avoid);
            foreach (pool[k])
                if (pool[k] == tok)
                    clash = 1'b1;
        end while (clash);
        return tok;
    endfunction

    function automatic logic [TOKEN_IN_W-1:0] pick_token(int noise_pct);
        if ($urandom_range(0, 99) < noise_pct)
            return TOKEN_IN_W'($urandom_range(0, 255));
        return pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Send one word; the sender runs in bursts with random gaps between them
    task automatic send_word(t_op op, logic [TOKEN_IN_W-1:0] tok);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind  <= op;
        item_ch.token <= tok;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        burst_left--;
        words_sent++;
        if (op == OP_LOAD)
            loads_sent++;
    endtask

    // Hold off until every expected result word has come back
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Mostly paragraph runs over the pool, some led by loads; some runs of pure noise
    task automatic run_mixed(int count);
        int sent;
        int run_len;
        sent = 0;
        while (sent < count) begin
            run_len = $urandom_range(5, 30);
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 99) < 40) begin
                    repeat ($urandom_range(1, 2)) begin
                        send_word(OP_LOAD, pool[$urandom_range(0, POOL_SIZE - 1)]);
                        sent++;
                    end
                end
                repeat (run_len) send_word(OP_PARA, pick_token(20));
            end else begin
                repeat (run_len) send_word(OP_PARA, pick_token(100));
            end
            sent += run_len;
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.kind    = OP_LOAD;
        item_ch.token   = '0;
        result_ch.ready = 1'b0;

        foreach (pool[k])
            pool[k] = '0;
        pool[1] = 8'hFF;
        for (int k = 2; k < POOL_SIZE; k++)
            pool[k] = fresh_token(8'h00);
        gate_tok  = fresh_token(8'h00);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing required yet: paragraph words are skipped
        send_word(OP_PARA, pool[0]);
        send_word(OP_PARA, pool[1]);
        send_word(OP_LOAD, pool[0]);
        send_word(OP_LOAD, pool[1]);
        // skip a non-target into an empty window, then cover and shrink
        send_word(OP_PARA, 8'h5A);
        send_word(OP_PARA, pool[1]);
        send_word(OP_PARA, 8'hA5);
        send_word(OP_PARA, pool[0]);
        // equal-length window keeps the earlier one, then a shorter one wins
        send_word(OP_PARA, pool[1]);
        // loads in the middle of the paragraph, with a repeated token
        send_word(OP_LOAD, pool[0]);
        send_word(OP_LOAD, pool[0]);
        send_word(OP_PARA, 8'h33);
        send_word(OP_PARA, pool[0]);
        send_word(OP_PARA, pool[0]);
        send_word(OP_PARA, pool[1]);
        send_word(OP_LOAD, pool[2]);
        send_word(OP_LOAD, pool[3]);
        send_word(OP_PARA, pool[3]);
        send_word(OP_PARA, pool[2]);
        send_word(OP_PARA, pool[1]);
        send_word(OP_PARA, pool[0]);
        send_word(OP_PARA, pool[0]);
        wait_drained();

        run_mixed(MIXED_WORDS);
        wait_drained();

        // require a token that stays absent until the ring has wrapped
        send_word(OP_LOAD, gate_tok);
        repeat (FILL_WORDS) send_word(OP_PARA, pick_token(0));
        send_word(OP_PARA, gate_tok);
        run_mixed(40);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (%0d loads): directed covers, mixed runs and a full",
                 words_sent, loads_sent);
        $display("ring; %0d result words compared against the predicted window.",
                 checked);
        if (fail_count == 0)
            $display("min_window_token_cover_top test passed");
        else
            $display("min_window_token_cover_top test failed");
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("min_window_token_cover_top test failed");
        $finish;
    end

endmodule
